// ===== rtl/mgc_pkg.sv =====
// shared types and constants for the mute group gain crossfade
package mgc_pkg;

    localparam int          ROWS_DEF       = 7;
    localparam int          FRAME_BITS_DEF = 48;
    localparam int          IN_FRAME_W     = 48;
    localparam int          MASK_W         = 7;
    localparam int          SPAN_W         = 24;
    localparam int          QUOT_W         = 16;
    localparam int          GAIN_W         = 16;
    localparam logic [15:0] UNITY_GAIN     = 16'd32768;
    localparam logic [15:0] NEAR_UNITY     = 16'd32765;
    // 3.0 in Q2.16 for the smoothstep polynomial
    localparam logic [17:0] SMOOTH_THREE   = 18'd196608;

    typedef struct packed {
        logic              start;
        logic [SPAN_W-1:0] num;
        logic [SPAN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/mgc_div.sv =====
// radix-2 restoring divider giving the q0.16 ramp position
module mgc_div
    import mgc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [SPAN_W-1:0] r_rem;
    logic [SPAN_W-1:0] r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [3:0]        r_cnt;
    logic              r_run;
    logic              r_done;
    logic [SPAN_W:0]   rem2;
    logic [SPAN_W:0]   diff;
    logic              ge;

    // numerator is below the divisor, so only the sixteen fraction bits remain
    assign rem2 = {r_rem, 1'b0};
    assign diff = rem2 - {1'b0, r_den};
    assign ge   = (rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_run) begin
            r_rem  <= ge ? diff[SPAN_W-1:0] : rem2[SPAN_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== rtl/mute_group_gain_crossfade.sv =====
// top level: per-row smoothstep mute gain ramps with recall and query
// Each input transaction produces exactly one output transaction. A query
// evaluates one row; a recall walks all ROWS rows in turn, capturing each
// row's gain at the start frame and arming its new ramp. A row evaluation
// goes from S_EVAL straight to S_POST when the ramp is idle, settled or not
// yet started. Mid-ramp it waits in S_DIV on the shared restoring divider
// for the ramp position (16 quotient bits), makes three passes through
// the single shared multiplier (t*t, times 3-2t, times the gain span),
// applies the step in S_APPLY and posts the result in S_POST. The block
// takes one transaction at a time: s_axis_tready is high only when it is
// idle. A finished result is held in an output register, so a new input
// is accepted while the previous result still waits on m_axis_tready.
module mute_group_gain_crossfade
    import mgc_pkg::*;
#(
    parameter int ROWS       = ROWS_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row[2:0], frame[50:3], mute bits[57:51], ramp length[81:58]
    input  logic [87:0] s_axis_tdata,
    // func[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // gain[15:0], suppressed[16], fade_end[64:17]
    output logic [71:0] m_axis_tdata
);

    localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int FW    = FRAME_BITS;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EVAL  = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_MUL1  = 9'b000001000,
        S_MUL2  = 9'b000010000,
        S_MUL3  = 9'b000100000,
        S_APPLY = 9'b001000000,
        S_POST  = 9'b010000000,
        S_RESP  = 9'b100000000
    } t_state;

    // per-row ramp state
    logic [GAIN_W-1:0] r_sg [ROWS];
    logic [FW-1:0]     r_sf [ROWS];
    logic [FW-1:0]     r_ef [ROWS];
    logic [ROWS-1:0]   r_tz;
    logic [ROWS-1:0]   r_mu;
    logic [ROWS-1:0]   r_nu;
    logic [FW-1:0]     r_lfe;

    t_state            r_state;
    logic              r_func;
    logic [IDX_W-1:0]  r_idx;
    logic [FW-1:0]     r_frame;
    logic [MASK_W-1:0] r_mask;
    logic              r_tf_zero;
    logic [FW-1:0]     r_end;
    logic [GAIN_W-1:0] r_gain;
    logic [QUOT_W-1:0] r_t;
    logic [49:0]       r_prod;
    logic              r_res_sup;
    logic [GAIN_W-1:0] r_res_gain;
    logic [FW-1:0]     r_res_fade;
    logic              r_ovalid;
    logic [71:0]       r_odata;

    logic              accept;
    logic              in_func;
    logic [2:0]        in_row;
    logic [FW-1:0]     in_frame;
    logic [MASK_W-1:0] in_mask;
    logic [SPAN_W-1:0] in_tf;
    logic [FW:0]       end_sum;
    logic [FW-1:0]     end_sat;
    logic              row_ok;
    logic [GAIN_W-1:0] sg;
    logic [FW-1:0]     st;
    logic [FW-1:0]     en;
    logic              tz;
    logic              nu;
    logic              zero_tgt;
    logic              settle;
    logic [FW-1:0]     span_full;
    logic [FW-1:0]     diff_full;
    logic [31:0]       mul_a;
    logic [17:0]       mul_b;
    logic [49:0]       mul_p;
    logic [GAIN_W-1:0] gspan;
    logic [GAIN_W-1:0] delta;
    logic [47:0]       fade_out;
    logic              out_free;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign in_func = s_axis_tuser[0];
    assign in_row  = s_axis_tdata[2:0];
    assign in_mask = s_axis_tdata[57:51];
    assign in_tf   = s_axis_tdata[81:58];

    // input frame masked or zero-extended to the frame counter width
    always_comb begin
        for (int i = 0; i < FW; i++) begin
            in_frame[i] = (i < IN_FRAME_W) ? s_axis_tdata[3 + (i % IN_FRAME_W)] : 1'b0;
        end
    end

    // recall end frame, saturated at the top of the frame counter
    assign end_sum = {1'b0, in_frame} + {{(FW + 1 - SPAN_W){1'b0}}, in_tf};
    assign end_sat = end_sum[FW] ? {FW{1'b1}} : end_sum[FW-1:0];
    assign row_ok  = ({{(32 - 3){1'b0}}, in_row} < 32'(ROWS));

    // selected row's ramp
    assign sg = r_sg[r_idx];
    assign st = r_sf[r_idx];
    assign en = r_ef[r_idx];
    assign tz = r_tz[r_idx];
    assign nu = r_nu[r_idx];

    // only the first seven rows have a mask bit
    always_comb begin
        zero_tgt = 1'b0;
        for (int i = 0; i < MASK_W; i++) begin
            if (32'(r_idx) == i) begin
                zero_tgt = r_mask[i];
            end
        end
    end

    assign settle    = (en <= st) || (r_frame >= en);
    assign span_full = en - st;
    assign diff_full = r_frame - st;

    // position divider starts on the cycle a live ramp is found
    assign div_req.start = (r_state == S_EVAL) && nu && (r_frame > st) && !settle;
    assign div_req.num   = diff_full[SPAN_W-1:0];
    assign div_req.den   = span_full[SPAN_W-1:0];

    mgc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // single shared multiplier, operands picked by the sequencer
    assign gspan = tz ? sg : (UNITY_GAIN - sg);
    always_comb begin
        case (r_state)
            S_MUL1: begin
                mul_a = {16'd0, r_t};
                mul_b = {2'd0, r_t};
            end
            S_MUL2: begin
                mul_a = r_prod[31:0];
                mul_b = SMOOTH_THREE - {1'b0, r_t, 1'b0};
            end
            S_MUL3: begin
                mul_a = {15'd0, r_prod[48:32]};
                mul_b = {2'd0, gspan};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = {18'd0, mul_a} * {32'd0, mul_b};
    assign delta = r_prod[31:16];

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_ovalid || m_axis_tready;

    // sequencer and row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tz    <= '0;
            r_mu    <= '0;
            r_nu    <= '0;
            r_lfe   <= '0;
            for (int i = 0; i < ROWS; i++) begin
                r_sg[i] <= UNITY_GAIN;
                r_sf[i] <= '0;
                r_ef[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func    <= in_func;
                        r_frame   <= in_frame;
                        r_mask    <= in_mask;
                        r_tf_zero <= (in_tf == '0);
                        r_end     <= end_sat;
                        if (in_func) begin
                            r_idx   <= '0;
                            r_state <= S_EVAL;
                        end else if (row_ok) begin
                            r_idx   <= IDX_W'(in_row);
                            r_state <= S_EVAL;
                        end else begin
                            // row without storage reads unity
                            r_res_gain <= UNITY_GAIN;
                            r_res_sup  <= 1'b0;
                            r_res_fade <= r_lfe;
                            r_state    <= S_RESP;
                        end
                    end
                end
                S_EVAL: begin
                    if (!nu) begin
                        r_gain  <= UNITY_GAIN;
                        r_state <= S_POST;
                    end else if (r_frame <= st) begin
                        r_gain  <= sg;
                        r_state <= S_POST;
                    end else if (settle) begin
                        // finished ramp lands on its target
                        r_gain       <= tz ? '0 : UNITY_GAIN;
                        r_sg[r_idx]  <= tz ? '0 : UNITY_GAIN;
                        r_sf[r_idx]  <= en;
                        r_mu[r_idx]  <= tz;
                        if (!tz) begin
                            r_nu[r_idx] <= 1'b0;
                        end
                        r_state <= S_POST;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_t     <= div_rsp.quot;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_prod  <= mul_p;
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_gain  <= tz ? (sg - delta) : (sg + delta);
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (!r_func) begin
                        r_res_gain <= r_gain;
                        r_res_sup  <= r_mu[r_idx] && r_tz[r_idx] && (r_ef[r_idx] <= r_frame);
                        r_res_fade <= r_lfe;
                        r_state    <= S_RESP;
                    end else begin
                        // arm the new ramp from the captured gain
                        r_sg[r_idx] <= r_gain;
                        r_tz[r_idx] <= zero_tgt;
                        r_sf[r_idx] <= r_frame;
                        r_ef[r_idx] <= r_end;
                        r_mu[r_idx] <= r_tf_zero && zero_tgt;
                        r_nu[r_idx] <= (r_gain < NEAR_UNITY) || zero_tgt;
                        if (32'(r_idx) == ROWS - 1) begin
                            r_lfe      <= r_end;
                            r_res_gain <= '0;
                            r_res_sup  <= 1'b0;
                            r_res_fade <= r_end;
                            r_state    <= S_RESP;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result frame fitted to the 48-bit output field
    always_comb begin
        for (int i = 0; i < 48; i++) begin
            fade_out[i] = (i < FW) ? r_res_fade[i % FW] : 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_RESP) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESP) && out_free) begin
            r_odata <= {7'd0, fade_out, r_res_sup, r_res_gain};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

`ifndef ASSERT_OFF
    a_div_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && div_rsp.done |=> (r_state == S_MUL1))
        else $error("divider result not taken");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (32'(r_idx) < ROWS))
        else $error("row index out of range");
    a_recall_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST) && r_func && (32'(r_idx) == ROWS - 1) |=> (r_lfe == $past(r_end)))
        else $error("last fade end not updated on recall");
    a_div_only_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (div_req.num < div_req.den))
        else $error("ramp position outside the ramp");
`endif

endmodule

// ===== dv/mute_group_gain_crossfade_tb.sv =====
// testbench for the mute group gain crossfade: directed table plus random traffic, scoreboarded
module mute_group_gain_crossfade_tb
    import mgc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS      = 7;
    localparam int N_RANDOM   = 700;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [47:0] FRAME_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic {FN_QUERY = 1'b0, FN_RECALL = 1'b1} t_func;

    typedef struct packed {
        logic [15:0] gain;
        logic        suppressed;
        logic [47:0] fade_end;
    } t_mix_out;

    typedef struct {
        t_func       func;
        logic [2:0]  row;
        logic [47:0] frame;
        logic [6:0]  mask;
        logic [23:0] tf;
        logic        has_exp;   // expected result typed into the table
        t_mix_out    exp;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // row[2:0], frame[50:3], mute bits[57:51], ramp length[81:58]
    logic [87:0] s_axis_tdata;
    // func[0]
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // gain[15:0], suppressed[16], fade_end[64:17]
    logic [71:0] m_axis_tdata;

    mute_group_gain_crossfade uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor copy of the per-row ramp state
    logic [15:0] mdl_start_gain [NROWS];
    logic        mdl_target_zero[NROWS];
    logic [47:0] mdl_start_frame[NROWS];
    logic [47:0] mdl_end_frame  [NROWS];
    logic        mdl_muted      [NROWS];
    logic [6:0]  mdl_non_unity;
    logic [47:0] mdl_last_end;

    t_mix_out expected_q[$];
    int  n_mismatch;
    int  n_results;
    int  n_recalls;
    int  n_queries;
    int  idle_cycles;
    bit  hold_off_req;   // asks the receiver for one long stall
    bit  stim_done;

    task automatic reset_ramps();
        for (int r = 0; r < NROWS; r++) begin
            mdl_start_gain[r]  = UNITY_GAIN;
            mdl_target_zero[r] = 1'b0;
            mdl_start_frame[r] = '0;
            mdl_end_frame[r]   = '0;
            mdl_muted[r]       = 1'b0;
        end
        mdl_non_unity = '0;
        mdl_last_end  = '0;
    endtask

    // gain of one row at a frame; settles a finished ramp
    function automatic logic [15:0] row_gain(int r, logic [47:0] frame);
        logic [47:0] st;
        logic [47:0] en;
        logic [63:0] span;
        logic [63:0] diff;
        logic [63:0] t;
        logic [63:0] s;
        logic [15:0] tgt;
        logic [15:0] g0;
        logic [31:0] delta;
        if (!mdl_non_unity[r]) return UNITY_GAIN;
        st = mdl_start_frame[r];
        en = mdl_end_frame[r];
        if (frame <= st) return mdl_start_gain[r];
        tgt = mdl_target_zero[r] ? 16'd0 : UNITY_GAIN;
        if (en <= st || frame >= en) begin
            mdl_start_gain[r]  = tgt;
            mdl_start_frame[r] = en;
            mdl_muted[r]       = mdl_target_zero[r];
            if (!mdl_target_zero[r]) mdl_non_unity[r] = 1'b0;
            return tgt;
        end
        span = 64'(en - st);
        diff = 64'(frame - st);
        t = (diff << 16) / span;
        if (t > 64'd65535) t = 64'd65535;
        s = (t * t * ((64'd3 << 16) - 64'd2 * t)) >> 32;
        g0 = mdl_start_gain[r];
        if (mdl_target_zero[r]) begin
            delta = 32'((64'(g0) * s) >> 16);
            return g0 - delta[15:0];
        end
        delta = 32'((64'(UNITY_GAIN - g0) * s) >> 16);
        return g0 + delta[15:0];
    endfunction

    function automatic t_mix_out predict_mix(t_stim_row it);
        t_mix_out    res;
        logic [48:0] sum;
        logic [47:0] en;
        logic [15:0] cur;
        logic        zero;
        res = '0;
        if (it.func == FN_QUERY) begin
            res.gain = UNITY_GAIN;
            if (it.row < NROWS) begin
                res.gain = row_gain(it.row, it.frame);
                res.suppressed = mdl_muted[it.row] && mdl_target_zero[it.row]
                               && mdl_end_frame[it.row] <= it.frame;
            end
            res.fade_end = mdl_last_end;
            return res;
        end
        sum = {1'b0, it.frame} + 49'(it.tf);
        en  = sum[48] ? FRAME_MAX : sum[47:0];
        for (int r = 0; r < NROWS; r++) begin
            cur  = row_gain(r, it.frame);
            zero = it.mask[r];
            mdl_start_gain[r]  = cur;
            mdl_target_zero[r] = zero;
            mdl_start_frame[r] = it.frame;
            mdl_end_frame[r]   = en;
            mdl_muted[r]       = (it.tf == 0) && zero;
            mdl_non_unity[r]   = (cur < NEAR_UNITY) || zero;
        end
        mdl_last_end = en;
        res.fade_end = en;
        return res;
    endfunction

    // ---------------- sender ----------------
    task automatic send_item(t_stim_row it);
        t_mix_out p;
        s_axis_tdata  <= {6'd0, it.tf, it.mask, it.frame, it.row};
        s_axis_tuser  <= it.func;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        // accepted at this edge: predict now, in acceptance order
        p = predict_mix(it);
        if (it.has_exp && p != it.exp)
            $display("note: table row disagrees with predictor (exp %h pred %h)", it.exp, p);
        expected_q.push_back(it.has_exp ? it.exp : p);
        if (it.func == FN_RECALL) n_recalls++; else n_queries++;
    endtask

    task automatic sender_gap();
        int g;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) g = 0;
        else if (pick < 92) g = $urandom_range(1, 4);
        else g = $urandom_range(20, 80);
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic t_stim_row mk(t_func f, int row, logic [47:0] frame,
                                     int mask, int tf);
        t_stim_row it;
        it.func = f; it.row = 3'(row); it.frame = frame;
        it.mask = 7'(mask); it.tf = 24'(tf);
        it.has_exp = 1'b0; it.exp = '0;
        return it;
    endfunction

    function automatic t_stim_row mk_exp(t_stim_row it, int gain, bit sup,
                                         logic [47:0] fe);
        it.has_exp = 1'b1;
        it.exp.gain = 16'(gain); it.exp.suppressed = sup; it.exp.fade_end = fe;
        return it;
    endfunction

    // random frame: mostly near the recent recall window, sometimes any value
    function automatic logic [47:0] rnd_frame(logic [47:0] base, int span);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 48'({$urandom(), $urandom()});
        if (pick == 1) return base;
        return base + 48'($urandom_range(0, span + span / 4 + 2));
    endfunction

    initial begin
        t_stim_row   tab[$];
        t_stim_row   it;
        logic [47:0] base;
        int          span;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        n_mismatch = 0; n_results = 0; n_recalls = 0; n_queries = 0;
        hold_off_req = 1'b0;
        stim_done = 1'b0;
        reset_ramps();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: after reset, extremes, special cases
        tab.push_back(mk_exp(mk(FN_QUERY, 0, 48'd0, 0, 0), 32768, 0, 48'd0));
        tab.push_back(mk_exp(mk(FN_QUERY, 7, FRAME_MAX, 0, 0), 32768, 0, 48'd0));
        // immediate mute of all rows
        tab.push_back(mk_exp(mk(FN_RECALL, 0, 48'd100, 127, 0), 0, 0, 48'd100));
        tab.push_back(mk(FN_QUERY, 0, 48'd100, 0, 0));   // start frame: captured gain
        tab.push_back(mk(FN_QUERY, 3, 48'd101, 0, 0));   // settles, suppressed
        tab.push_back(mk_exp(mk(FN_QUERY, 7, 48'd500, 0, 0), 32768, 0, 48'd100));
        // fade back up over 1000 frames
        tab.push_back(mk(FN_RECALL, 0, 48'd1000, 0, 1000));
        tab.push_back(mk(FN_QUERY, 0, 48'd1250, 0, 0));
        tab.push_back(mk(FN_QUERY, 1, 48'd1500, 0, 0));
        tab.push_back(mk(FN_QUERY, 2, 48'd1999, 0, 0));
        tab.push_back(mk(FN_QUERY, 4, 48'd999, 0, 0));
        // recall mid ramp captures partial gains
        tab.push_back(mk(FN_RECALL, 0, 48'd1700, 7'h55, 24'hFFFFFF));
        tab.push_back(mk(FN_QUERY, 0, 48'd5000000, 0, 0));
        tab.push_back(mk(FN_QUERY, 1, 48'd9000000, 0, 0));
        tab.push_back(mk(FN_QUERY, 6, FRAME_MAX, 0, 0));
        tab.push_back(mk(FN_QUERY, 5, FRAME_MAX, 0, 0));
        // end saturation
        tab.push_back(mk_exp(mk(FN_RECALL, 0, FRAME_MAX - 48'd5, 7'h2A, 24'hFFFFFF),
                             0, 0, FRAME_MAX));
        tab.push_back(mk(FN_QUERY, 1, FRAME_MAX - 48'd2, 0, 0));
        tab.push_back(mk(FN_QUERY, 1, FRAME_MAX, 0, 0));
        tab.push_back(mk(FN_QUERY, 0, FRAME_MAX, 0, 0));
        tab.push_back(mk(FN_RECALL, 0, 48'd0, 0, 1));
        tab.push_back(mk(FN_QUERY, 1, 48'd0, 0, 0));
        tab.push_back(mk(FN_QUERY, 1, 48'd1, 0, 0));
        foreach (tab[k]) begin
            send_item(tab[k]);
            sender_gap();
        end

        // random part: recall followed by queries into its ramp window
        base = 48'd0;
        span = 1;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) hold_off_req = 1'b1;
            if (n == 400) begin
                // sender drains the block before going on
                s_axis_tvalid <= 1'b0;
                while (expected_q.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) < 2) begin
                base = ($urandom_range(0, 19) == 0) ? 48'({$urandom(), $urandom()})
                                                    : base + 48'($urandom_range(0, 5000));
                case ($urandom_range(0, 5))
                    0: span = 0;
                    1: span = $urandom_range(1, 8);
                    2: span = 24'hFFFFFF;
                    3: span = $urandom() & 24'hFFFFFF;
                    default: span = $urandom_range(10, 3000);
                endcase
                it = mk(FN_RECALL, $urandom_range(0, 7), base, $urandom_range(0, 127), span);
            end else begin
                it = mk(FN_QUERY, $urandom_range(0, 7), rnd_frame(base, span), 0, 0);
                // unused fields still toggle
                it.mask = 7'($urandom());
                it.tf = 24'($urandom());
            end
            send_item(it);
            sender_gap();
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // ---------------- receiver ----------------
    initial begin
        int g;
        int pick;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                // long stall so the output register fills and input stalls
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) g = 0;
            else if (pick < 95) g = $urandom_range(1, 5);
            else g = $urandom_range(30, 120);
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // scoreboard: compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_mix_out got;
        t_mix_out exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.gain       = m_axis_tdata[15:0];
            got.suppressed = m_axis_tdata[16];
            got.fade_end   = m_axis_tdata[64:17];
            n_results++;
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected output transaction: %h", m_axis_tdata);
            end else begin
                exp = expected_q.pop_front();
                if (got.gain !== exp.gain || got.suppressed !== exp.suppressed
                    || got.fade_end !== exp.fade_end) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch #%0d: gain %0d/%0d sup %0b/%0b end %0h/%0h",
                                 n_results, exp.gain, got.gain, exp.suppressed,
                                 got.suppressed, exp.fade_end, got.fade_end);
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout, %0d transactions still expected", expected_q.size());
                $display("*** FAILED ***");
                $finish;
            end
            if (stim_done && expected_q.size() == 0) begin
                repeat (300) @(posedge i_clk);
                if (expected_q.size() != 0) n_mismatch++;
                $display("covered %0d recalls and %0d queries, %0d results checked",
                         n_recalls, n_queries, n_results);
                $display("%0d mismatches", n_mismatch);
                if (n_mismatch == 0)
                    $display("*** PASSED ***");
                else
                    $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
